// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by led_strip_effect_generator_top.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/led_fx_pkg.sv =====
// ---------------------------------------------------------------------------
// led_fx_pkg
// Types and constants of the LED strip effect generator.
// ---------------------------------------------------------------------------
package led_fx_pkg;

    localparam int MAX_LEDS = 64;
    localparam int IDX_W    = $clog2(MAX_LEDS);
    localparam int CNT_W    = IDX_W + 1;

    // Effect modes; codes five to seven behave as off.
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_SOLID   = 3'd1;
    localparam logic [2:0] MODE_FLOW    = 3'd2;
    localparam logic [2:0] MODE_BLINK   = 3'd3;
    localparam logic [2:0] MODE_BREATHE = 3'd4;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_RED       = 3'd1;
    localparam logic [2:0] REG_GREEN     = 3'd2;
    localparam logic [2:0] REG_BLUE      = 3'd3;
    localparam logic [2:0] REG_FLOW_LEN  = 3'd4;
    localparam logic [2:0] REG_STEP      = 3'd5;
    localparam logic [2:0] REG_LED_COUNT = 3'd6;

    localparam logic [7:0]       STEP_RESET  = 8'd26;
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_LEDS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_BR_R,
        ST_BR_G,
        ST_BR_B,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/led_strip_effect_generator_top.sv =====
// After a tick request the sequencer brings the flow position below the LED count (up to 63
// subtractions, one per cycle), in breathing mode steps the shared multiplier through the three
// channels (one channel per cycle), then gives one result per cycle for each LED in use while
// the output does not stall. In breathing mode the flow position is always 0. Reset clears the
// sequencer, the output valid flag, the flow position and the first LED colour, and loads the
// register reset values.
// ---------------------------------------------------------------------------
// led_strip_effect_generator_top
// Computes one animation frame per tick and streams each LED's colour in GRB order.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module led_strip_effect_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] led_index, [13:6] green, [21:14] red,
                                        // [29:22] blue, [31:30] zero
    output logic        m_axis_tlast
);

    localparam int IDX_W = led_fx_pkg::IDX_W;
    localparam int CNT_W = led_fx_pkg::CNT_W;

    // Configuration registers
    logic [2:0]       mode_reg;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;
    logic [CNT_W-1:0] flow_len_reg;
    logic [7:0]       step_reg;
    logic [CNT_W-1:0] led_count_reg;

    // Animation state
    logic [IDX_W-1:0] flow_pos_reg,  flow_pos_next;
    logic [7:0]       first_r_reg,   first_r_next;
    logic [7:0]       first_g_reg,   first_g_next;
    logic [7:0]       first_b_reg,   first_b_next;

    // Sequencer and frame working registers
    led_fx_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] pos_reg,  pos_next;
    logic [IDX_W-1:0] idx_reg,  idx_next;
    logic [IDX_W-1:0] off_reg,  off_next;
    logic [7:0]       r_reg,    r_next;
    logic [7:0]       g_reg,    g_next;
    logic [7:0]       b_reg,    b_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_idx_reg,   out_idx_next;
    logic [7:0]       out_g_reg,     out_g_next;
    logic [7:0]       out_r_reg,     out_r_next;
    logic [7:0]       out_b_reg,     out_b_next;
    logic             out_last_reg,  out_last_next;

    logic [CNT_W-1:0] n_w;
    logic [CNT_W-1:0] len_w;
    logic             tick_req;
    logic             load_out;
    logic             last_led;
    logic             lit;
    logic [7:0]       led_r, led_g, led_b;

    // Shared breathing unit
    logic [7:0]  br_target;
    logic [7:0]  br_last;
    logic [15:0] br_prod;
    logic [8:0]  br_sum;
    logic [7:0]  br_result;

    // Effective LED count and window length
    always_comb
    begin
        if (led_count_reg == '0)
        begin
            n_w = CNT_W'(1);
        end
        else if (led_count_reg > led_fx_pkg::COUNT_RESET)
        begin
            n_w = led_fx_pkg::COUNT_RESET;
        end
        else
        begin
            n_w = led_count_reg;
        end
        len_w = (flow_len_reg > n_w) ? n_w : flow_len_reg;
    end

    assign tick_req = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];
    assign load_out = (state_reg == led_fx_pkg::ST_EMIT) && (!out_valid_reg || m_axis_tready);
    assign last_led = (({1'b0, idx_reg} + CNT_W'(1)) == n_w);
    assign lit      = ({1'b0, off_reg} < len_w);

    // One multiplier serves the three channels in turn.
    always_comb
    begin
        unique case (state_reg)
            led_fx_pkg::ST_BR_G:
            begin
                br_target = green_reg;
                br_last   = first_g_reg;
            end
            led_fx_pkg::ST_BR_B:
            begin
                br_target = blue_reg;
                br_last   = first_b_reg;
            end
            default:
            begin
                br_target = red_reg;
                br_last   = first_r_reg;
            end
        endcase
        br_prod   = br_target * step_reg;
        br_sum    = {1'b0, br_last} + {1'b0, br_prod[15:8]};
        br_result = (br_sum > {1'b0, br_target}) ? br_target : br_sum[7:0];
    end

    always_comb
    begin
        if (mode_reg == led_fx_pkg::MODE_FLOW)
        begin
            led_r = lit ? red_reg   : 8'd0;
            led_g = lit ? green_reg : 8'd0;
            led_b = lit ? blue_reg  : 8'd0;
        end
        else
        begin
            led_r = r_reg;
            led_g = g_reg;
            led_b = b_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            led_fx_pkg::ST_IDLE:
            begin
                if (tick_req)
                begin
                    state_next = led_fx_pkg::ST_WRAP;
                end
            end
            led_fx_pkg::ST_WRAP:
            begin
                if (pos_reg < n_w)
                begin
                    state_next = (mode_reg == led_fx_pkg::MODE_BREATHE) ?
                                 led_fx_pkg::ST_BR_R : led_fx_pkg::ST_EMIT;
                end
            end
            led_fx_pkg::ST_BR_R: state_next = led_fx_pkg::ST_BR_G;
            led_fx_pkg::ST_BR_G: state_next = led_fx_pkg::ST_BR_B;
            led_fx_pkg::ST_BR_B: state_next = led_fx_pkg::ST_EMIT;
            led_fx_pkg::ST_EMIT:
            begin
                if (load_out && last_led)
                begin
                    state_next = led_fx_pkg::ST_IDLE;
                end
            end
            default: state_next = led_fx_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        off_next       = off_reg;
        r_next         = r_reg;
        g_next         = g_reg;
        b_next         = b_reg;
        flow_pos_next  = flow_pos_reg;
        first_r_next   = first_r_reg;
        first_g_next   = first_g_reg;
        first_b_next   = first_b_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_idx_next   = out_idx_reg;
        out_g_next     = out_g_reg;
        out_r_next     = out_r_reg;
        out_b_next     = out_b_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            led_fx_pkg::ST_IDLE:
            begin
                if (tick_req)
                begin
                    pos_next = {1'b0, flow_pos_reg};
                    r_next   = 8'd0;
                    g_next   = 8'd0;
                    b_next   = 8'd0;
                    // Blinking lights the strip only if the first LED was fully dark.
                    if ((mode_reg == led_fx_pkg::MODE_SOLID) ||
                        ((mode_reg == led_fx_pkg::MODE_BLINK) && (first_r_reg == 8'd0) &&
                         (first_g_reg == 8'd0) && (first_b_reg == 8'd0)))
                    begin
                        r_next = red_reg;
                        g_next = green_reg;
                        b_next = blue_reg;
                    end
                end
            end
            led_fx_pkg::ST_WRAP:
            begin
                if (pos_reg >= n_w)
                begin
                    pos_next = pos_reg - n_w;
                end
                else
                begin
                    idx_next = '0;
                    // Distance of LED 0 from the start of the lit window.
                    off_next = (pos_reg == '0) ? '0 : IDX_W'(n_w - pos_reg);
                end
            end
            led_fx_pkg::ST_BR_R: r_next = br_result;
            led_fx_pkg::ST_BR_G: g_next = br_result;
            led_fx_pkg::ST_BR_B: b_next = br_result;
            led_fx_pkg::ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = idx_reg;
                    out_r_next     = led_r;
                    out_g_next     = led_g;
                    out_b_next     = led_b;
                    out_last_next  = last_led;
                    if (idx_reg == '0)
                    begin
                        first_r_next = led_r;
                        first_g_next = led_g;
                        first_b_next = led_b;
                    end
                    if (last_led)
                    begin
                        if (mode_reg == led_fx_pkg::MODE_FLOW)
                        begin
                            flow_pos_next = ((pos_reg + CNT_W'(1)) == n_w) ?
                                            '0 : IDX_W'(pos_reg + CNT_W'(1));
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        off_next = (({1'b0, off_reg} + CNT_W'(1)) == n_w) ?
                                   '0 : off_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_axis_tready;
            end
        endcase

        // Writing the mode restarts the flowing window.
        if (cfg_we && (cfg_index == led_fx_pkg::REG_MODE))
        begin
            flow_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= led_fx_pkg::MODE_OFF;
            red_reg       <= 8'd0;
            green_reg     <= 8'd0;
            blue_reg      <= 8'd0;
            flow_len_reg  <= '0;
            step_reg      <= led_fx_pkg::STEP_RESET;
            led_count_reg <= led_fx_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                led_fx_pkg::REG_MODE:      mode_reg      <= cfg_data[2:0];
                led_fx_pkg::REG_RED:       red_reg       <= cfg_data;
                led_fx_pkg::REG_GREEN:     green_reg     <= cfg_data;
                led_fx_pkg::REG_BLUE:      blue_reg      <= cfg_data;
                led_fx_pkg::REG_FLOW_LEN:  flow_len_reg  <= cfg_data[CNT_W-1:0];
                led_fx_pkg::REG_STEP:      step_reg      <= cfg_data;
                led_fx_pkg::REG_LED_COUNT: led_count_reg <= cfg_data[CNT_W-1:0];
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= led_fx_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            flow_pos_reg  <= '0;
            first_r_reg   <= 8'd0;
            first_g_reg   <= 8'd0;
            first_b_reg   <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            flow_pos_reg  <= flow_pos_next;
            first_r_reg   <= first_r_next;
            first_g_reg   <= first_g_next;
            first_b_reg   <= first_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        off_reg      <= off_next;
        r_reg        <= r_next;
        g_reg        <= g_next;
        b_reg        <= b_next;
        out_idx_reg  <= out_idx_next;
        out_g_reg    <= out_g_next;
        out_r_reg    <= out_r_next;
        out_b_reg    <= out_b_next;
        out_last_reg <= out_last_next;
    end

    assign s_axis_tready = (state_reg == led_fx_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_b_reg, out_r_reg, out_g_reg, out_idx_reg};

    `ASSERT_SAME(a_last_matches_count, clk, rst_n, m_axis_tvalid && m_axis_tlast,
        ({1'b0, out_idx_reg} + CNT_W'(1)) == n_w, "frame end not on the last LED")
    `ASSERT_SAME(a_emit_index_range, clk, rst_n, state_reg == led_fx_pkg::ST_EMIT,
        ({1'b0, idx_reg} < n_w) && ({1'b0, off_reg} < n_w), "LED index or offset out of range")
    `ASSERT_NEXT(a_frame_closes, clk, rst_n, load_out && last_led,
        state_reg == led_fx_pkg::ST_IDLE && m_axis_tvalid, "frame did not close after last LED")

endmodule
